### src/plst_pkg.sv
// plst_pkg: shared codes, widths and types of the positional list store
// no dependencies; used by plst_ctrl, plst_store and positional_list_store_unit
package plst_pkg;

    // field widths of one word on the command and result side
    localparam int KIND_W   = 2;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

    // decoded update for the entry array
    typedef struct packed {
        logic             ins;   // open a slot at idx and write the new word
        logic             del;   // close the slot at idx
        logic             hit;   // position is valid, read data is meaningful
        logic [POS_W-1:0] idx;   // zero-based slot index
    } t_op;

endpackage

### src/positional_list_store_unit.sv
// positional_list_store_unit: top level of the bounded positional list store
// depends on plst_pkg, plst_ctrl and plst_store
//
// usage
//   command side: a word (i_kind, i_position, i_item_value) is taken at a
//   rising edge with start high and busy low; busy is never raised, so one
//   command may be issued every cycle
//   result side: o_valid marks o_status, o_read_value and o_length for
//   exactly one cycle; the receiver has no way to hold results off
//   path: the command register is loaded at the command edge; decode and
//   entry shift feed the result register, which drives the result
//   throughput: one command per cycle; each command sees the list left by
//   the one before it, because the entry registers and the count update at
//   the same edge that registers the result
//   reset: i_rst_n low, synchronous, empties the list and drops any word in
//   flight; stored entries keep their contents but are unreachable
//   positions are 1-based; insert accepts 1 to count+1, delete and read
//   accept 1 to count
module positional_list_store_unit #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [plst_pkg::KIND_W-1:0]   i_kind,
    input  logic [plst_pkg::POS_W-1:0]    i_position,
    input  logic [plst_pkg::DATA_W-1:0]   i_item_value,
    output logic                          o_valid,
    output logic [plst_pkg::STATUS_W-1:0] o_status,
    output logic [plst_pkg::DATA_W-1:0]   o_read_value,
    output logic [plst_pkg::LEN_W-1:0]    o_length
);

    // command register
    logic                          r_in_vld;
    logic [plst_pkg::KIND_W-1:0]   r_kind;
    logic [plst_pkg::POS_W-1:0]    r_pos;
    logic [plst_pkg::DATA_W-1:0]   r_val;

    // list length
    logic [plst_pkg::LEN_W-1:0]    r_count;
    logic [plst_pkg::LEN_W-1:0]    n_count;

    // result register
    logic                          r_out_vld;
    logic [plst_pkg::STATUS_W-1:0] r_status;
    logic [plst_pkg::DATA_W-1:0]   r_rd;
    logic [plst_pkg::LEN_W-1:0]    r_len;

    plst_pkg::t_op                 op;
    plst_pkg::t_op                 op_gated;
    logic [plst_pkg::STATUS_W-1:0] status;
    logic [plst_pkg::DATA_W-1:0]   rd_value;

    assign busy = 1'b0;

    // capture the command word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_kind <= i_kind;
            r_pos  <= i_position;
            r_val  <= i_item_value;
        end
    end

    // decode against the current count
    plst_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_kind       (r_kind),
        .i_position   (r_pos),
        .i_count      (r_count),
        .o_op         (op),
        .o_status     (status),
        .o_next_count (n_count)
    );

    // only a live command may touch the entries
    always_comb begin
        op_gated     = op;
        op_gated.ins = op.ins && r_in_vld;
        op_gated.del = op.del && r_in_vld;
    end

    plst_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .i_clk        (i_clk),
        .i_en         (r_in_vld),
        .i_op         (op_gated),
        .i_item_value (r_val),
        .o_read_value (rd_value)
    );

    // count and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
            if (r_in_vld) begin
                r_count <= n_count;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_status <= status;
            r_rd     <= rd_value;
            r_len    <= n_count;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_status     = r_status;
    assign o_read_value = r_rd;
    assign o_length     = r_len;

`ifndef ASSERT_OFF
    // the count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= plst_pkg::LEN_W'(CAPACITY))
        else $error("list count above capacity");

    // every result traces back to a command taken through the command and result registers
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, 2))
        else $error("result without a command");

    // a refused or unknown command returns a zero word
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != plst_pkg::ST_OK)) |-> (o_read_value == '0))
        else $error("nonzero word on failed command");

    // a read leaves the count alone
    a_read_keeps_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && (r_kind == plst_pkg::KIND_READ)) |=> $stable(r_count))
        else $error("read changed the count");

    // a refused command reports the unchanged length
    a_fail_keeps_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && (status != plst_pkg::ST_OK)) |=> (o_length == $past(r_count)))
        else $error("failed command changed the length");
`endif

endmodule

### src/plst_ctrl.sv
// plst_ctrl: decodes one registered command against the current count
// depends on plst_pkg
module plst_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic [plst_pkg::KIND_W-1:0]   i_kind,
    input  logic [plst_pkg::POS_W-1:0]    i_position,
    input  logic [plst_pkg::LEN_W-1:0]    i_count,
    output plst_pkg::t_op                 o_op,
    output logic [plst_pkg::STATUS_W-1:0] o_status,
    output logic [plst_pkg::LEN_W-1:0]    o_next_count
);

    localparam logic [plst_pkg::LEN_W-1:0] CAP_L = plst_pkg::LEN_W'(CAPACITY);

    logic                         full;
    logic                         empty;
    logic                         pos_nz;
    logic [plst_pkg::LEN_W:0]     count_p1;

    assign full     = (i_count >= CAP_L);
    assign empty    = (i_count == '0);
    assign pos_nz   = (i_position != '0);
    assign count_p1 = {1'b0, i_count} + (plst_pkg::LEN_W+1)'(1);

    // status and update decode
    always_comb begin
        o_op.ins     = 1'b0;
        o_op.del     = 1'b0;
        o_op.hit     = 1'b0;
        o_op.idx     = i_position - plst_pkg::POS_W'(1);
        o_status     = plst_pkg::ST_BADPOS;
        o_next_count = i_count;
        case (i_kind)
            plst_pkg::KIND_INSERT: begin
                if (full) begin
                    o_status = plst_pkg::ST_FULL;
                end else if (pos_nz && ({1'b0, i_position} <= count_p1)) begin
                    o_status     = plst_pkg::ST_OK;
                    o_op.ins     = 1'b1;
                    o_next_count = count_p1[plst_pkg::LEN_W-1:0];
                end
            end
            plst_pkg::KIND_DELETE, plst_pkg::KIND_READ: begin
                if (empty) begin
                    o_status = plst_pkg::ST_EMPTY;
                end else if (pos_nz && (i_position <= i_count)) begin
                    o_status = plst_pkg::ST_OK;
                    o_op.hit = 1'b1;
                    if (i_kind == plst_pkg::KIND_DELETE) begin
                        o_op.del     = 1'b1;
                        o_next_count = i_count - plst_pkg::LEN_W'(1);
                    end
                end
            end
            default: begin
                o_status = plst_pkg::ST_BADPOS;
            end
        endcase
    end

endmodule

### src/plst_store.sv
// plst_store: entry registers that shift up on insert and down on delete
// depends on plst_pkg
module plst_store #(
    parameter int CAPACITY = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  plst_pkg::t_op               i_op,
    input  logic [plst_pkg::DATA_W-1:0] i_item_value,
    output logic [plst_pkg::DATA_W-1:0] o_read_value
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [plst_pkg::DATA_W-1:0] r_entry [CAPACITY];
    logic [plst_pkg::DATA_W-1:0] n_entry [CAPACITY];

    // every slot picks from itself, a neighbour or the new word in parallel
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_entry[i] = r_entry[i];
            if (i_op.ins) begin
                if (plst_pkg::POS_W'(i) == i_op.idx) begin
                    n_entry[i] = i_item_value;
                end else if ((i > 0) && (plst_pkg::POS_W'(i) > i_op.idx)) begin
                    n_entry[i] = r_entry[(i > 0) ? i - 1 : 0];
                end
            end else if (i_op.del) begin
                if ((i < CAPACITY - 1) && (plst_pkg::POS_W'(i) >= i_op.idx)) begin
                    n_entry[i] = r_entry[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
        end
    end

    // entry registers, payload only
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < CAPACITY; i++) begin
                r_entry[i] <= n_entry[i];
            end
        end
    end

    // read the addressed word before any shift
    assign o_read_value = i_op.hit ? r_entry[i_op.idx[AW-1:0]] : '0;

endmodule
